// File: hdl/wts_pkg.sv
package wts_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 64;
  localparam int COEF_W    = 32;
  localparam int COORD_W   = 32;
  localparam int CLIP_W    = 58;
  localparam int DEPTH_W   = 31;
  localparam int K_W       = 21;
  localparam int QBITS     = 34;
  localparam int LO_W      = 29;
  localparam int N_W       = 80;
  localparam int DIV_LAT   = QBITS + 3;
  localparam int SAT_W     = 37;

  localparam int DEF_SCREEN_W = 1920;
  localparam int DEF_SCREEN_H = 1080;

  localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(656);

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_W = 3;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] regs_t;

  typedef struct packed {
    logic                     vld;
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [CLIP_W-1:0] cw;
  } clip_t;

  localparam regs_t REG_RESET = '{
    64'h0001_0000_0000_0000,
    64'h0,
    64'h0000_0000_0001_0000,
    64'h0,
    64'h0,
    64'h0001_0000_0000_0000,
    64'h0,
    64'h0000_0000_0001_0000
  };

  function automatic logic signed [COEF_W-1:0] coef(regs_t regs, int row, int col);
    logic [REG_W-1:0] r;
    r = regs[REG_IDX_W'((row << 1) + (col >> 1))];
    return (col & 1) != 0 ? r[REG_W-1:COEF_W] : r[COEF_W-1:0];
  endfunction

endpackage

// File: hdl/wts_clip.sv
module wts_clip (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic signed [wts_pkg::COORD_W-1:0]     x,
  input  logic signed [wts_pkg::COORD_W-1:0]     y,
  input  logic signed [wts_pkg::COORD_W-1:0]     z,
  input  wts_pkg::regs_t                         regs,
  output wts_pkg::clip_t                         clip
);
  import wts_pkg::*;

  localparam int ROWS [3] = '{ROW_X, ROW_Y, ROW_W};

  logic signed [2*COORD_W-1:0] prod [3][3];
  logic signed [CLIP_W-1:0]    part_a [3];
  logic signed [CLIP_W-1:0]    part_b [3];
  logic signed [CLIP_W-1:0]    sum [3];
  logic                        vld1, vld2, vld3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        prod[r][0] <= coef(regs, ROWS[r], 0) * x;
        prod[r][1] <= coef(regs, ROWS[r], 1) * y;
        prod[r][2] <= coef(regs, ROWS[r], 2) * z;
        part_a[r]  <= CLIP_W'(prod[r][0] >>> 8) + CLIP_W'(prod[r][1] >>> 8);
        part_b[r]  <= CLIP_W'(prod[r][2] >>> 8) + CLIP_W'(coef(regs, ROWS[r], 3));
        sum[r]     <= part_a[r] + part_b[r];
      end
    end
  end

  assign clip.vld = vld3;
  assign clip.cx  = sum[0];
  assign clip.cy  = sum[1];
  assign clip.cw  = sum[2];

endmodule

// File: hdl/wts_div.sv
module wts_div #(
  parameter int K = 122880
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 neg,
  input  logic [wts_pkg::CLIP_W-1:0]           mag,
  input  logic [wts_pkg::CLIP_W-1:0]           w,
  output logic signed [wts_pkg::COORD_W-1:0]   s
);
  import wts_pkg::*;

  localparam logic [K_W-1:0] KV = K_W'(K);
  localparam int HI_W = CLIP_W - LO_W;

  logic [LO_W+K_W-1:0]  pl;
  logic [HI_W+K_W-1:0]  ph;
  logic [CLIP_W-1:0]    w0;
  logic                 neg0;
  logic [N_W-1:0]       n_full;

  logic [CLIP_W-1:0]    rem   [QBITS+1];
  logic [QBITS-1:0]     nlo   [QBITS+1];
  logic [QBITS-1:0]     quo   [QBITS+1];
  logic [CLIP_W-1:0]    wd    [QBITS+1];
  logic                 negd  [QBITS+1];
  logic                 ovfd  [QBITS+1];

  logic [QBITS:0]        t;
  logic signed [SAT_W-1:0] sv;

  assign n_full = (N_W'(ph) << LO_W) + N_W'(pl);

  always_ff @(posedge clk) begin
    if (en) begin
      pl      <= mag[LO_W-1:0] * KV;
      ph      <= mag[CLIP_W-1:LO_W] * KV;
      w0      <= w;
      neg0    <= neg;
      rem[0]  <= CLIP_W'(n_full[N_W-1:QBITS]);
      nlo[0]  <= n_full[QBITS-1:0];
      quo[0]  <= '0;
      wd[0]   <= w0;
      negd[0] <= neg0;
      ovfd[0] <= (CLIP_W'(n_full[N_W-1:QBITS]) >= w0);
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_step
    logic [CLIP_W:0] rs;
    logic            ge;
    assign rs = {rem[i], nlo[i][QBITS-1-i]};
    assign ge = rs >= {1'b0, wd[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? CLIP_W'(rs - {1'b0, wd[i]}) : CLIP_W'(rs);
        nlo[i+1]  <= nlo[i];
        quo[i+1]  <= {quo[i][QBITS-2:0], ge};
        wd[i+1]   <= wd[i];
        negd[i+1] <= negd[i];
        ovfd[i+1] <= ovfd[i];
      end
    end
  end

  always_comb begin
    t  = ovfd[QBITS] ? {1'b1, {QBITS{1'b0}}} : {1'b0, quo[QBITS]};
    sv = negd[QBITS] ? $signed({{(SAT_W-K_W){1'b0}}, KV}) + $signed({2'b0, t})
                     : $signed({{(SAT_W-K_W){1'b0}}, KV}) - $signed({2'b0, t});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sv > $signed(SAT_W'(32'sh7fff_ffff))) begin
        s <= 32'sh7fff_ffff;
      end else if (sv < -$signed(SAT_W'(33'sh0_8000_0000))) begin
        s <= 32'sh8000_0000;
      end else begin
        s <= sv[COORD_W-1:0];
      end
    end
  end

endmodule

// File: hdl/world_to_screen_projection.sv
// World-to-screen projection pipeline.
// The input channel (in_valid, in_stall) carries one world point per item as
// pos_x, pos_y and pos_z in signed Q23.8. The output channel (out_valid,
// out_stall) returns one item per point: visible, screen_x, screen_y and depth.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) loads
// the eight 64-bit clip matrix registers; cfg_ready is always high. The user
// must make writes only while no item is in flight (not enforced by the block).
// Throughput is one item per cycle while the output is not stalled. Each
// item passes the matrix product, partial sum and sum registers, a setup
// register for sign and magnitude, a restoring divider for each coordinate
// that resolves one quotient bit per stage, and the output register.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle, so no item is lost or repeated.
module world_to_screen_projection #(
  parameter int SCREEN_W = wts_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H = wts_pkg::DEF_SCREEN_H
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [wts_pkg::COORD_W-1:0]   pos_x,
  input  logic signed [wts_pkg::COORD_W-1:0]   pos_y,
  input  logic signed [wts_pkg::COORD_W-1:0]   pos_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 visible,
  output logic signed [wts_pkg::COORD_W-1:0]   screen_x,
  output logic signed [wts_pkg::COORD_W-1:0]   screen_y,
  output logic [wts_pkg::DEPTH_W-1:0]          depth,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wts_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [wts_pkg::REG_W-1:0]            cfg_data
);
  import wts_pkg::*;

  localparam int KX = SCREEN_W * 128;
  localparam int KY = SCREEN_H * 128;

  regs_t                regs;
  clip_t                clip;
  logic                 en;

  logic                 vld4, vis4, negx4, negy4;
  logic [CLIP_W-1:0]    magx4, magy4, w4;
  logic [DEPTH_W-1:0]   dep4;

  logic                 vld_d [DIV_LAT+1];
  logic                 vis_d [DIV_LAT+1];
  logic [DEPTH_W-1:0]   dep_d [DIV_LAT+1];

  logic signed [COORD_W-1:0] sx, sy;
  logic signed [CLIP_W-1:0]  cw_sh;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  wts_clip u_clip (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_valid),
    .x      (pos_x),
    .y      (pos_y),
    .z      (pos_z),
    .regs   (regs),
    .clip   (clip)
  );

  assign cw_sh = clip.cw >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      vis4  <= clip.cw >= W_MIN;
      negx4 <= clip.cx < 0;
      negy4 <= clip.cy < 0;
      magx4 <= clip.cx < 0 ? CLIP_W'(-clip.cx) : CLIP_W'(clip.cx);
      magy4 <= clip.cy < 0 ? CLIP_W'(-clip.cy) : CLIP_W'(clip.cy);
      w4    <= CLIP_W'(clip.cw);
      dep4  <= (cw_sh[CLIP_W-1:DEPTH_W] != '0) ? {DEPTH_W{1'b1}} : cw_sh[DEPTH_W-1:0];
    end
  end

  wts_div #(.K(KX)) u_div_x (
    .clk (clk),
    .en  (en),
    .neg (negx4),
    .mag (magx4),
    .w   (w4),
    .s   (sx)
  );

  wts_div #(.K(KY)) u_div_y (
    .clk (clk),
    .en  (en),
    .neg (negy4),
    .mag (magy4),
    .w   (w4),
    .s   (sy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
      for (int i = 0; i <= DIV_LAT; i++) begin
        vld_d[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld4     <= clip.vld;
      vld_d[0] <= vld4;
      for (int i = 0; i < DIV_LAT; i++) begin
        vld_d[i+1] <= vld_d[i];
      end
      out_valid <= vld_d[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_d[0] <= vis4;
      dep_d[0] <= dep4;
      for (int i = 0; i < DIV_LAT; i++) begin
        vis_d[i+1] <= vis_d[i];
        dep_d[i+1] <= dep_d[i];
      end
      visible  <= vis_d[DIV_LAT-1];
      screen_x <= vis_d[DIV_LAT-1] ? sx : '0;
      screen_y <= vis_d[DIV_LAT-1] ? sy : '0;
      depth    <= vis_d[DIV_LAT-1] ? dep_d[DIV_LAT-1] : '0;
    end
  end

endmodule

// File: hdl/wts_chk.sv
module wts_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 visible,
  input logic signed [wts_pkg::COORD_W-1:0]   screen_x,
  input logic signed [wts_pkg::COORD_W-1:0]   screen_y,
  input logic [wts_pkg::DEPTH_W-1:0]          depth
);

  a_stall_follows : assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a blocked output");

  a_hidden_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> screen_x == 0 && screen_y == 0 && depth == 0)
    else $error("hidden point with nonzero fields");

  a_visible_depth : assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> depth >= 2)
    else $error("visible point with depth below threshold");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(screen_y))
    else $error("stalled item changed");

endmodule

bind world_to_screen_projection wts_chk u_wts_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .visible   (visible),
  .screen_x  (screen_x),
  .screen_y  (screen_y),
  .depth     (depth)
);
